// ===== src/tilt_shake_gesture_detector_core_defines.svh =====
// Assertion macros shared by the tilt and shake gesture detector files.
`ifndef TILT_SHAKE_GESTURE_DETECTOR_CORE_DEFINES_SVH
`define TILT_SHAKE_GESTURE_DETECTOR_CORE_DEFINES_SVH

// Checked on every rising edge of aclk, ignored while reset is asserted.
`define TSG_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("tsg assertion failed");

// Checked on every rising edge of aclk, reset included.
`define TSG_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) (prop)) \
        else $error("tsg assertion failed");

`endif

// ===== src/tsg_pkg.sv =====
// Types, constants and helpers for the tilt and shake gesture detector.
package tsg_pkg;

    typedef enum logic [2:0] {
        GEST_NONE  = 3'd0,
        GEST_FWD   = 3'd1,
        GEST_BWD   = 3'd2,
        GEST_LEFT  = 3'd3,
        GEST_RIGHT = 3'd4,
        GEST_SHAKE = 3'd5
    } gesture_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FWD_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BWD_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAT_THR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_DLT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_CNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_TIME = 3'd6;

    localparam logic signed [15:0] RST_FWD_THR   = -16'sd10000;
    localparam logic signed [15:0] RST_BWD_THR   = 16'sd14000;
    localparam logic [14:0]        RST_LAT_THR   = 15'd10000;
    localparam logic [15:0]        RST_SHAKE_DLT = 16'd8000;
    localparam logic [3:0]         RST_SHAKE_CNT = 4'd3;
    localparam logic [15:0]        RST_HOLD_TIME = 16'd1000;
    localparam logic [15:0]        RST_TILT_TIME = 16'd500;

    typedef struct packed {
        logic signed [15:0] fwd_thr;
        logic signed [15:0] bwd_thr;
        logic [14:0]        lat_thr;
        logic [15:0]        shake_dlt;
        logic [3:0]         shake_cnt;
        logic [15:0]        hold_time;
        logic [15:0]        tilt_time;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic [31:0]        t;
    } sample_t;

    // |a - b| at full 17-bit width
    function automatic logic [16:0] abs_diff(input logic signed [15:0] a,
                                             input logic signed [15:0] b);
        logic signed [16:0] d;
        d = 17'(a) - 17'(b);
        abs_diff = d[16] ? 17'(-d) : 17'(d);
    endfunction

endpackage

// ===== src/tsg_cfg.sv =====
// Configuration register file of the gesture detector.
module tsg_cfg import tsg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fwd_thr   <= RST_FWD_THR;
            cfg_reg.bwd_thr   <= RST_BWD_THR;
            cfg_reg.lat_thr   <= RST_LAT_THR;
            cfg_reg.shake_dlt <= RST_SHAKE_DLT;
            cfg_reg.shake_cnt <= RST_SHAKE_CNT;
            cfg_reg.hold_time <= RST_HOLD_TIME;
            cfg_reg.tilt_time <= RST_TILT_TIME;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FWD_THR:   cfg_reg.fwd_thr   <= cfg_wdata;
                CFG_BWD_THR:   cfg_reg.bwd_thr   <= cfg_wdata;
                CFG_LAT_THR:   cfg_reg.lat_thr   <= cfg_wdata[14:0];
                CFG_SHAKE_DLT: cfg_reg.shake_dlt <= cfg_wdata;
                CFG_SHAKE_CNT: cfg_reg.shake_cnt <= cfg_wdata[3:0];
                CFG_HOLD_TIME: cfg_reg.hold_time <= cfg_wdata;
                CFG_TILT_TIME: cfg_reg.tilt_time <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/tsg_detect.sv =====
// Gesture decision logic and the per-gesture tracking state.
module tsg_detect import tsg_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  cfg_t     cfg,
    input  sample_t  smp,
    output gesture_t gesture
);

    `include "tilt_shake_gesture_detector_core_defines.svh"

    logic [31:0]        fwd_start_reg, fwd_start_next;
    logic               fwd_armed_reg, fwd_armed_next;
    logic               fwd_fired_reg, fwd_fired_next;
    logic [31:0]        bwd_start_reg, bwd_start_next;
    logic               bwd_armed_reg, bwd_armed_next;
    logic               bwd_fired_reg, bwd_fired_next;
    logic [31:0]        left_start_reg, left_start_next;
    logic               left_armed_reg, left_armed_next;
    logic [31:0]        right_start_reg, right_start_next;
    logic               right_armed_reg, right_armed_next;
    logic signed [15:0] prev_x_reg, prev_x_next;
    logic signed [15:0] prev_y_reg, prev_y_next;
    logic signed [15:0] prev_z_reg, prev_z_next;
    logic [3:0]         jolt_run_reg, jolt_run_next;

    always_comb begin
        logic               done;
        logic signed [15:0] lat_pos;
        logic signed [15:0] lat_neg;
        logic [31:0]        el_fwd, el_bwd, el_left, el_right;
        logic               jolt;
        logic [4:0]         run_inc;

        fwd_start_next   = fwd_start_reg;
        fwd_armed_next   = fwd_armed_reg;
        fwd_fired_next   = fwd_fired_reg;
        bwd_start_next   = bwd_start_reg;
        bwd_armed_next   = bwd_armed_reg;
        bwd_fired_next   = bwd_fired_reg;
        left_start_next  = left_start_reg;
        left_armed_next  = left_armed_reg;
        right_start_next = right_start_reg;
        right_armed_next = right_armed_reg;
        prev_x_next      = prev_x_reg;
        prev_y_next      = prev_y_reg;
        prev_z_next      = prev_z_reg;
        jolt_run_next    = jolt_run_reg;
        gesture          = GEST_NONE;
        done             = 1'b0;

        lat_pos  = $signed({1'b0, cfg.lat_thr});
        lat_neg  = -lat_pos;
        el_fwd   = smp.t - fwd_start_reg;
        el_bwd   = smp.t - bwd_start_reg;
        el_left  = smp.t - left_start_reg;
        el_right = smp.t - right_start_reg;
        jolt     = (abs_diff(smp.ax, prev_x_reg) > {1'b0, cfg.shake_dlt}) ||
                   (abs_diff(smp.ay, prev_y_reg) > {1'b0, cfg.shake_dlt}) ||
                   (abs_diff(smp.az, prev_z_reg) > {1'b0, cfg.shake_dlt});
        run_inc  = {1'b0, jolt_run_reg} + 5'd1;

        if (smp.ax < cfg.fwd_thr) begin
            if (!fwd_armed_reg) begin
                fwd_armed_next = 1'b1;
                fwd_start_next = smp.t;
                fwd_fired_next = 1'b0;
            end else if (!fwd_fired_reg && el_fwd >= {16'd0, cfg.hold_time}) begin
                fwd_fired_next = 1'b1;
                gesture        = GEST_FWD;
                done           = 1'b1;
            end
        end else begin
            fwd_armed_next = 1'b0;
            fwd_start_next = '0;
            fwd_fired_next = 1'b0;
        end

        if (!done) begin
            if (smp.ax > cfg.bwd_thr) begin
                if (!bwd_armed_reg) begin
                    bwd_armed_next = 1'b1;
                    bwd_start_next = smp.t;
                    bwd_fired_next = 1'b0;
                end else if (!bwd_fired_reg && el_bwd >= {16'd0, cfg.hold_time}) begin
                    bwd_fired_next = 1'b1;
                    gesture        = GEST_BWD;
                    done           = 1'b1;
                end
            end else begin
                bwd_armed_next = 1'b0;
                bwd_start_next = '0;
                bwd_fired_next = 1'b0;
            end
        end

        if (!done) begin
            if (smp.ay > lat_pos) begin
                if (!left_armed_reg) begin
                    left_armed_next = 1'b1;
                    left_start_next = smp.t;
                end else if (el_left >= {16'd0, cfg.tilt_time}) begin
                    left_armed_next = 1'b0;
                    left_start_next = '0;
                    gesture         = GEST_LEFT;
                    done            = 1'b1;
                end
            end else begin
                left_armed_next = 1'b0;
                left_start_next = '0;
            end
        end

        if (!done) begin
            if (smp.ay < lat_neg) begin
                if (!right_armed_reg) begin
                    right_armed_next = 1'b1;
                    right_start_next = smp.t;
                end else if (el_right >= {16'd0, cfg.tilt_time}) begin
                    right_armed_next = 1'b0;
                    right_start_next = '0;
                    gesture          = GEST_RIGHT;
                    done             = 1'b1;
                end
            end else begin
                right_armed_next = 1'b0;
                right_start_next = '0;
            end
        end

        if (!done) begin
            prev_x_next = smp.ax;
            prev_y_next = smp.ay;
            prev_z_next = smp.az;
            if (jolt) begin
                if (run_inc > {1'b0, cfg.shake_cnt}) begin
                    jolt_run_next = '0;
                    gesture       = GEST_SHAKE;
                end else begin
                    jolt_run_next = run_inc[3:0];
                end
            end else begin
                jolt_run_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_start_reg   <= '0;
            fwd_armed_reg   <= 1'b0;
            fwd_fired_reg   <= 1'b0;
            bwd_start_reg   <= '0;
            bwd_armed_reg   <= 1'b0;
            bwd_fired_reg   <= 1'b0;
            left_start_reg  <= '0;
            left_armed_reg  <= 1'b0;
            right_start_reg <= '0;
            right_armed_reg <= 1'b0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            prev_z_reg      <= '0;
            jolt_run_reg    <= '0;
        end else if (en) begin
            fwd_start_reg   <= fwd_start_next;
            fwd_armed_reg   <= fwd_armed_next;
            fwd_fired_reg   <= fwd_fired_next;
            bwd_start_reg   <= bwd_start_next;
            bwd_armed_reg   <= bwd_armed_next;
            bwd_fired_reg   <= bwd_fired_next;
            left_start_reg  <= left_start_next;
            left_armed_reg  <= left_armed_next;
            right_start_reg <= right_start_next;
            right_armed_reg <= right_armed_next;
            prev_x_reg      <= prev_x_next;
            prev_y_reg      <= prev_y_next;
            prev_z_reg      <= prev_z_next;
            jolt_run_reg    <= jolt_run_next;
        end
    end

    // a hold can only have fired while its timer is armed
    `TSG_ASSERT_ALWAYS(a_fwd_fired_armed, fwd_fired_reg |-> fwd_armed_reg)
    `TSG_ASSERT_ALWAYS(a_bwd_fired_armed, bwd_fired_reg |-> bwd_armed_reg)
    // state moves only on a processed sample
    `TSG_ASSERT(a_hold_when_idle, !en |=> ($stable(jolt_run_reg) && $stable(prev_x_reg)
        && $stable(fwd_armed_reg) && $stable(left_armed_reg)))

endmodule

// ===== src/tilt_shake_gesture_detector_core.sv =====
// Top level of the tilt and shake gesture detector.
// One accelerometer sample is accepted per clock while the result side does not
// stall, and one gesture code comes out per sample, in order. A transferred
// sample sits in the input register while the decision logic updates the
// tracking state, and the result register is loaded once the result side can
// take it. The rate is one sample per cycle while the result side does not
// stall, set by the loop from the tracking state through the decision logic
// back to itself. When the result side stalls, one further sample is held in
// the input register. Configuration writes must be made only while no sample
// is in flight.
module tilt_shake_gesture_detector_core import tsg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // accel_x[15:0], accel_y[31:16], accel_z[47:32], time_ms[79:48]
    input  logic [79:0]           s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // gesture[2:0], zero padding[7:3]
    output logic [7:0]            m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    `include "tilt_shake_gesture_detector_core_defines.svh"

    cfg_t     cfg;
    sample_t  smp_reg;
    logic     in_valid_reg;
    logic     out_valid_reg;
    gesture_t gest_reg;
    gesture_t gest_next;
    logic     proc_en;
    logic     s_xfer;

    assign proc_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc_en;
    assign s_xfer   = s_tvalid && s_tready;

    tsg_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tsg_detect u_detect (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (proc_en),
        .cfg     (cfg),
        .smp     (smp_reg),
        .gesture (gest_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_xfer) begin
            smp_reg.ax <= s_tdata[15:0];
            smp_reg.ay <= s_tdata[31:16];
            smp_reg.az <= s_tdata[47:32];
            smp_reg.t  <= s_tdata[79:48];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (proc_en) begin
            gest_reg <= gest_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, gest_reg};

    `TSG_ASSERT(a_result_follows, proc_en |=> out_valid_reg)
    `TSG_ASSERT(a_full_stall, (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
    `TSG_ASSERT(a_gesture_range, out_valid_reg |-> (gest_reg == GEST_NONE ||
        gest_reg == GEST_FWD || gest_reg == GEST_BWD || gest_reg == GEST_LEFT ||
        gest_reg == GEST_RIGHT || gest_reg == GEST_SHAKE))

endmodule

// ===== bench/tilt_shake_gesture_detector_core_test.sv =====
// Self-checking bench for the gesture detector: directed probes, then random episodes.
`timescale 1ns / 1ps

module tilt_shake_gesture_detector_core_test;
    import tsg_pkg::*;

    localparam int N_PROBES    = 24;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 160;
    localparam int QUIET_LIMIT = 2000;

    // no register at this index; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    typedef enum int {EP_NOISE, EP_FWD, EP_BWD, EP_LEFT, EP_RIGHT, EP_SHAKE} episode_t;

    typedef struct packed {
        int          x;
        int          y;
        int          z;
        logic [31:0] t;
        logic        pinned;
        gesture_t    g;
    } probe_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [79:0]           s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // rows with pinned = 1 carry the gesture expected from the reset settings
    probe_t probes [N_PROBES] = '{
        '{     0,      0,      0, 32'd0,         1'b1, GEST_NONE },
        '{-32768,      0,      0, 32'd100,       1'b1, GEST_NONE },
        '{-32768,      0,      0, 32'd1100,      1'b1, GEST_FWD  },
        '{-32768,      0,      0, 32'd5000,      1'b1, GEST_NONE },
        '{ 32767,      0,      0, 32'd5000,      1'b1, GEST_NONE },
        '{ 32767,      0,      0, 32'd6000,      1'b1, GEST_BWD  },
        '{     0,  32767,      0, 32'd6000,      1'b1, GEST_NONE },
        '{     0,  32767,      0, 32'd6500,      1'b1, GEST_LEFT },
        '{     0, -32768,      0, 32'd7000,      1'b1, GEST_NONE },
        '{     0, -32768,      0, 32'd7500,      1'b1, GEST_RIGHT},
        '{     0,      0,  32767, 32'd8000,      1'b1, GEST_SHAKE},
        '{     0,      0, -32768, 32'd8001,      1'b1, GEST_NONE },
        '{     0,      0,  32767, 32'd8002,      1'b1, GEST_NONE },
        '{     0,      0, -32768, 32'd8003,      1'b1, GEST_NONE },
        '{     0,      0,  32767, 32'd8004,      1'b1, GEST_SHAKE},
        // hold spanning the timestamp wrap
        '{-32768,      0,  32767, 32'hFFFF_FF00, 1'b1, GEST_NONE },
        '{-32768,      0,  32767, 32'h0000_02E8, 1'b1, GEST_FWD  },
        '{-32768,      0,  32767, 32'h0000_03E8, 1'b1, GEST_NONE },
        // values on and just past each threshold
        '{-10000,  10000,      0, 32'h0000_0400, 1'b0, GEST_NONE },
        '{ 14000, -10000,      0, 32'h0000_0500, 1'b0, GEST_NONE },
        '{-10001,  10001,   8000, 32'h0000_0600, 1'b0, GEST_NONE },
        '{ 14001, -10001,   8000, 32'h0000_0700, 1'b0, GEST_NONE },
        '{     0,      0,      0, 32'h0000_0800, 1'b0, GEST_NONE },
        '{  8000,  -8000,   8000, 32'h0000_0900, 1'b0, GEST_NONE }
    };

    cfg_t               cur_cfg;
    logic [31:0]        fwd_t0, bwd_t0, left_t0, right_t0;
    logic               fwd_on, fwd_done, bwd_on, bwd_done, left_on, right_on;
    logic signed [15:0] last_x, last_y, last_z;
    logic [3:0]         jolts;

    gesture_t gest_q [$];
    logic     pin_valid = 1'b0;
    gesture_t pin_gest  = GEST_NONE;
    int       err_count = 0;
    int       quiet     = 0;
    int       stall_left = 0;
    int       gap_pct   = 20;
    int       stall_pct = 20;
    bit       calm      = 1'b0;

    tilt_shake_gesture_detector_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int axis_swing(input logic signed [15:0] a, input logic signed [15:0] b);
        int d;
        d = $signed(a) - $signed(b);
        return (d < 0) ? -d : d;
    endfunction

    function automatic gesture_t classify_sample(input sample_t smp);
        int          xv, yv, lat, dlt;
        logic [31:0] held;
        logic [4:0]  run_next;
        logic        jolt;
        xv  = $signed(smp.ax);
        yv  = $signed(smp.ay);
        lat = int'(cur_cfg.lat_thr);
        dlt = int'(cur_cfg.shake_dlt);

        if (xv < $signed(cur_cfg.fwd_thr)) begin
            if (!fwd_on) begin
                fwd_on   = 1'b1;
                fwd_t0   = smp.t;
                fwd_done = 1'b0;
            end else begin
                held = smp.t - fwd_t0;
                if (!fwd_done && held >= 32'(cur_cfg.hold_time)) begin
                    fwd_done = 1'b1;
                    return GEST_FWD;
                end
            end
        end else begin
            fwd_on   = 1'b0;
            fwd_t0   = '0;
            fwd_done = 1'b0;
        end

        if (xv > $signed(cur_cfg.bwd_thr)) begin
            if (!bwd_on) begin
                bwd_on   = 1'b1;
                bwd_t0   = smp.t;
                bwd_done = 1'b0;
            end else begin
                held = smp.t - bwd_t0;
                if (!bwd_done && held >= 32'(cur_cfg.hold_time)) begin
                    bwd_done = 1'b1;
                    return GEST_BWD;
                end
            end
        end else begin
            bwd_on   = 1'b0;
            bwd_t0   = '0;
            bwd_done = 1'b0;
        end

        if (yv > lat) begin
            if (!left_on) begin
                left_on = 1'b1;
                left_t0 = smp.t;
            end else begin
                held = smp.t - left_t0;
                if (held >= 32'(cur_cfg.tilt_time)) begin
                    left_on = 1'b0;
                    left_t0 = '0;
                    return GEST_LEFT;
                end
            end
        end else begin
            left_on = 1'b0;
            left_t0 = '0;
        end

        if (yv < -lat) begin
            if (!right_on) begin
                right_on = 1'b1;
                right_t0 = smp.t;
            end else begin
                held = smp.t - right_t0;
                if (held >= 32'(cur_cfg.tilt_time)) begin
                    right_on = 1'b0;
                    right_t0 = '0;
                    return GEST_RIGHT;
                end
            end
        end else begin
            right_on = 1'b0;
            right_t0 = '0;
        end

        jolt = axis_swing(smp.ax, last_x) > dlt || axis_swing(smp.ay, last_y) > dlt ||
               axis_swing(smp.az, last_z) > dlt;
        last_x = smp.ax;
        last_y = smp.ay;
        last_z = smp.az;
        if (jolt) begin
            run_next = {1'b0, jolts} + 5'd1;
            if (run_next > {1'b0, cur_cfg.shake_cnt}) begin
                jolts = '0;
                return GEST_SHAKE;
            end
            jolts = run_next[3:0];
        end else begin
            jolts = '0;
        end
        return GEST_NONE;
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= 100) begin
            $display("%0t: mismatch: %s", $time, what);
        end
    endtask

    task automatic send_sample(input sample_t smp, input logic pinned, input gesture_t pin_g);
        int gap;
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {smp.t, smp.az, smp.ay, smp.ax};
        pin_valid <= pinned;
        pin_gest  <= pin_g;
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    task automatic await_gestures();
        @(posedge aclk);
        while (gest_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic configure(input int phase);
        logic [15:0] fwd_v, bwd_v, lat_v, dlt_v, cnt_v, hold_v, tilt_v;
        case (phase)
            1: begin
                fwd_v  = 16'h8000;
                bwd_v  = 16'h7FFF;
                lat_v  = 16'h8000;
                dlt_v  = 16'h0000;
                cnt_v  = 16'hFFF0;
                hold_v = 16'h0000;
                tilt_v = 16'h0000;
            end
            2: begin
                fwd_v  = 16'h7FFF;
                bwd_v  = 16'h8000;
                lat_v  = 16'hFFFF;
                dlt_v  = 16'hFFFF;
                cnt_v  = 16'h000F;
                hold_v = 16'hFFFF;
                tilt_v = 16'hFFFF;
            end
            3: begin
                fwd_v  = 16'($urandom);
                bwd_v  = 16'($urandom);
                lat_v  = 16'($urandom);
                dlt_v  = 16'($urandom);
                cnt_v  = 16'($urandom);
                hold_v = 16'($urandom);
                tilt_v = 16'($urandom);
            end
            N_PHASES - 1: begin
                fwd_v  = RST_FWD_THR;
                bwd_v  = RST_BWD_THR;
                lat_v  = {1'($urandom), RST_LAT_THR};
                dlt_v  = RST_SHAKE_DLT;
                cnt_v  = {12'($urandom), RST_SHAKE_CNT};
                hold_v = RST_HOLD_TIME;
                tilt_v = RST_TILT_TIME;
            end
            default: begin
                fwd_v  = 16'(-int'($urandom_range(2000, 20000)));
                bwd_v  = 16'($urandom_range(2000, 20000));
                lat_v  = {1'($urandom), 15'($urandom_range(0, 20000))};
                dlt_v  = 16'($urandom_range(0, 30000));
                cnt_v  = 16'($urandom);
                hold_v = 16'($urandom_range(0, 3000));
                tilt_v = 16'($urandom_range(0, 1500));
            end
        endcase
        write_setting(CFG_FWD_THR, fwd_v);
        write_setting(CFG_BWD_THR, bwd_v);
        write_setting(CFG_LAT_THR, lat_v);
        write_setting(CFG_SHAKE_DLT, dlt_v);
        write_setting(CFG_SHAKE_CNT, cnt_v);
        write_setting(CFG_HOLD_TIME, hold_v);
        write_setting(CFG_TILT_TIME, tilt_v);
        write_setting(CFG_SPARE, 16'($urandom));
        cfg_we <= 1'b0;
    endtask

    // episodes of held tilts and shakes with random content, mixed with noise
    task automatic run_phase(input int n_items);
        episode_t    ep;
        int          ep_left, axis, xv, yv, zv, swing, fwd, bwd, lat, dlt, i;
        logic [31:0] now_ms;
        bit          flip;
        sample_t     smp;
        fwd     = $signed(cur_cfg.fwd_thr);
        bwd     = $signed(cur_cfg.bwd_thr);
        lat     = int'(cur_cfg.lat_thr);
        dlt     = int'(cur_cfg.shake_dlt);
        now_ms  = $urandom;
        ep      = EP_NOISE;
        ep_left = 0;
        axis    = 0;
        flip    = 1'b0;
        for (i = 0; i < n_items; i++) begin
            if (ep_left == 0) begin
                ep      = episode_t'($urandom_range(0, 5));
                ep_left = $urandom_range(2, 12);
                axis    = $urandom_range(0, 2);
            end
            ep_left--;
            xv = int'($urandom_range(0, 4000)) - 2000;
            yv = int'($urandom_range(0, 4000)) - 2000;
            zv = int'($urandom_range(0, 4000)) - 2000;
            case (ep)
                EP_NOISE: begin
                    xv = int'($urandom_range(0, 65535)) - 32768;
                    yv = int'($urandom_range(0, 65535)) - 32768;
                    zv = int'($urandom_range(0, 65535)) - 32768;
                    now_ms += $urandom_range(0, 3000);
                    if ($urandom_range(0, 15) == 0) now_ms = $urandom;
                end
                EP_FWD: begin
                    if (fwd > -32768) xv = -32768 + int'($urandom_range(0, fwd + 32767));
                    now_ms += $urandom_range(0, int'(cur_cfg.hold_time) / 3 + 2);
                end
                EP_BWD: begin
                    if (bwd < 32767) xv = bwd + 1 + int'($urandom_range(0, 32766 - bwd));
                    now_ms += $urandom_range(0, int'(cur_cfg.hold_time) / 3 + 2);
                end
                EP_LEFT: begin
                    if (lat < 32767) yv = lat + 1 + int'($urandom_range(0, 32766 - lat));
                    now_ms += $urandom_range(0, int'(cur_cfg.tilt_time) / 3 + 2);
                end
                EP_RIGHT: begin
                    yv = -32768 + int'($urandom_range(0, 32767 - lat));
                    now_ms += $urandom_range(0, int'(cur_cfg.tilt_time) / 3 + 2);
                end
                default: begin
                    swing = dlt / 2 + 1 + int'($urandom_range(0, 2000));
                    if (swing > 32767) swing = 32767;
                    flip = !flip;
                    case (axis)
                        0:       xv = flip ? swing : -swing;
                        1:       yv = flip ? swing : -swing;
                        default: zv = flip ? swing : -swing;
                    endcase
                    now_ms += $urandom_range(0, 50);
                end
            endcase
            smp.ax = 16'(xv);
            smp.ay = 16'(yv);
            smp.az = 16'(zv);
            smp.t  = now_ms;
            send_sample(smp, 1'b0, GEST_NONE);
        end
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (aresetn && !calm && $urandom_range(0, 99) < stall_pct) begin
            stall_left <= $urandom_range(0, 3);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : track_b
        gesture_t want;
        sample_t  smp;
        if (!aresetn) begin
            cur_cfg = '{fwd_thr: RST_FWD_THR, bwd_thr: RST_BWD_THR, lat_thr: RST_LAT_THR,
                        shake_dlt: RST_SHAKE_DLT, shake_cnt: RST_SHAKE_CNT,
                        hold_time: RST_HOLD_TIME, tilt_time: RST_TILT_TIME};
            {fwd_t0, bwd_t0, left_t0, right_t0} = '0;
            {fwd_on, fwd_done, bwd_on, bwd_done, left_on, right_on} = '0;
            {last_x, last_y, last_z} = '0;
            jolts = '0;
            gest_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_FWD_THR:   cur_cfg.fwd_thr   = cfg_wdata;
                    CFG_BWD_THR:   cur_cfg.bwd_thr   = cfg_wdata;
                    CFG_LAT_THR:   cur_cfg.lat_thr   = cfg_wdata[14:0];
                    CFG_SHAKE_DLT: cur_cfg.shake_dlt = cfg_wdata;
                    CFG_SHAKE_CNT: cur_cfg.shake_cnt = cfg_wdata[3:0];
                    CFG_HOLD_TIME: cur_cfg.hold_time = cfg_wdata;
                    CFG_TILT_TIME: cur_cfg.tilt_time = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                smp.ax = s_tdata[15:0];
                smp.ay = s_tdata[31:16];
                smp.az = s_tdata[47:32];
                smp.t  = s_tdata[79:48];
                want   = classify_sample(smp);
                if (pin_valid) want = pin_gest;
                gest_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                if (gest_q.size() == 0) begin
                    report_mismatch($sformatf("gesture %0d with no sample pending",
                                              m_tdata[2:0]));
                end else begin
                    want = gest_q.pop_front();
                    if (m_tdata !== {5'b0, want}) begin
                        report_mismatch($sformatf("m_tdata %h, expected %s", m_tdata,
                                                  want.name()));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("tilt_shake_gesture_detector_core_test failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        sample_t smp;
        int      i, p;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < N_PROBES; i++) begin
            smp.ax = 16'(probes[i].x);
            smp.ay = 16'(probes[i].y);
            smp.az = 16'(probes[i].z);
            smp.t  = probes[i].t;
            send_sample(smp, probes[i].pinned, probes[i].g);
        end
        run_phase(PHASE_ITEMS);

        for (p = 1; p < N_PHASES; p++) begin
            s_tvalid <= 1'b0;
            await_gestures();
            calm = (p == N_PHASES - 1);
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                default: gap_pct = 35;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 10;
                default: stall_pct = 35;
            endcase
            configure(p);
            run_phase(PHASE_ITEMS);
        end

        s_tvalid <= 1'b0;
        await_gestures();
        repeat (8) @(posedge aclk);
        if (err_count == 0) begin
            $display("tilt_shake_gesture_detector_core_test passed");
        end else begin
            $display("tilt_shake_gesture_detector_core_test failed");
        end
        $finish;
    end

endmodule
